// ===== sv/kml_pkg.sv =====
// ----------------------------------------------------------------------------
// kml_pkg
// Shared codes, state encoding and controller/datapath bundles for the
// k-means clustering engine.
// ----------------------------------------------------------------------------
package kml_pkg;

  // operation codes carried by an input beat
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_SEED   = 3'd1;
  localparam logic [2:0] OP_RUN    = 3'd2;
  localparam logic [2:0] OP_RD_ASG = 3'd3;
  localparam logic [2:0] OP_RD_CEN = 3'd4;

  // register indexes on the APB port
  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_DIMS     = 2'd1;
  localparam logic [1:0] REG_POINTS   = 2'd2;
  localparam logic [1:0] REG_EPOCHS   = 2'd3;

  localparam logic [4:0]  RST_CLUSTERS = 5'd4;
  localparam logic [5:0]  RST_DIMS     = 6'd32;
  localparam logic [10:0] RST_POINTS   = 11'd1024;
  localparam logic [5:0]  RST_EPOCHS   = 6'd20;

  localparam int FRAC_W = 8;
  localparam int COORD_W = 9;
  localparam int CEN_W = 17;
  localparam int ASG_W = 4;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_RD_OUT,
    ST_EP_CLR,
    ST_DIST,
    ST_DIST_WAIT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_ASSIGN,
    ST_UPD_CHK,
    ST_UPD_RD,
    ST_UPD_DIV,
    ST_UPD_WAIT,
    ST_EP_NEXT,
    ST_RUN_OUT
  } kml_state_e;

  typedef struct packed {
    logic in_rdy;
    logic pt_we;
    logic pt_re;
    logic pt_sel_req;
    logic cen_re;
    logic cen_sel_req;
    logic cen_we_seed;
    logic cen_we_upd;
    logic sum_re;
    logic sum_sel_best;
    logic sum_we_clr;
    logic sum_we_acc;
    logic asg_re;
    logic asg_we_clr;
    logic asg_we_run;
    logic cnt_clr;
    logic cnt_inc;
    logic dist_vld;
    logic dist_first;
    logic dist_last;
    logic div_start;
    logic out_ld_asg;
    logic out_ld_cen;
    logic out_ld_run;
  } kml_cmd_t;

  typedef struct packed {
    logic       in_vld;
    logic [2:0] op;
    logic       load_ok;
    logic       seed_ok;
    logic       dist_busy;
    logic       cnt_zero;
    logic       div_done;
    logic       out_free;
  } kml_stat_t;

endpackage

// ===== sv/kml_in_if.sv =====
// ----------------------------------------------------------------------------
// kml_in_if
// Operation channel: valid/ready with one operation per beat.
// ----------------------------------------------------------------------------
interface kml_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [9:0] point_index;
  logic [4:0] dim_index;
  logic [3:0] cluster_index;
  logic [8:0] coordinate_value;

  modport source (output valid, output operation, output point_index, output dim_index,
                  output cluster_index, output coordinate_value, input ready);
  modport sink (input valid, input operation, input point_index, input dim_index,
                input cluster_index, input coordinate_value, output ready);
endinterface

// ===== sv/kml_out_if.sv =====
// ----------------------------------------------------------------------------
// kml_out_if
// Result channel: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
interface kml_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  assigned_cluster;
  logic [16:0] centroid_value;
  logic        run_done;

  modport source (output valid, output assigned_cluster, output centroid_value,
                  output run_done, input ready);
  modport sink (input valid, input assigned_cluster, input centroid_value,
                input run_done, output ready);
endinterface

// ===== sv/kml_ram.sv =====
// ----------------------------------------------------------------------------
// kml_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kml_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                                wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [W-1:0]                                rdata_o
);
  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/kml_div.sv =====
// ----------------------------------------------------------------------------
// kml_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module kml_div #(
  parameter int NW = 27,
  parameter int DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   dvd_q;
  logic [DW-1:0]   rem_q, dvs_q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DW'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[DW-1:0];
      end
      dvd_q <= {dvd_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
endmodule

// ===== sv/kml_ctrl.sv =====
// ----------------------------------------------------------------------------
// kml_ctrl
// Sequencer: walks operations, epochs, points, clusters and dimensions and
// drives the datapath through the command bundle.
// ----------------------------------------------------------------------------
module kml_ctrl import kml_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]             k_last_i,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] d_last_i,
  input  logic [$clog2(MAX_POINTS)-1:0]               n_last_i,
  input  logic [5:0]                                  e_last_i,
  input  kml_stat_t                                   stat_i,
  output kml_cmd_t                                    cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]               p_o,
  output logic [$clog2(MAX_CLUSTERS)-1:0]             c_o,
  output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] d_o
);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int CLW = $clog2(MAX_CLUSTERS);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  kml_state_e     s_q, s_d;
  logic [PW-1:0]  p_q, p_d;
  logic [CLW-1:0] c_q, c_d;
  logic [DW-1:0]  d_q, d_d;
  logic [5:0]     e_q, e_d;
  logic           d_end, c_end, p_end;

  assign d_end = d_q == d_last_i;
  assign c_end = c_q == k_last_i;
  assign p_end = p_q == n_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= ST_CLEAR;
      p_q <= '0;
      c_q <= '0;
      d_q <= '0;
      e_q <= '0;
    end else begin
      s_q <= s_d;
      p_q <= p_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
    end
  end

  always_comb begin
    s_d = s_q;
    p_d = p_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    case (s_q)
      ST_CLEAR: begin
        if (p_q == PW'(MAX_POINTS - 1)) begin
          p_d = '0;
          s_d = ST_IDLE;
        end else begin
          p_d = p_q + PW'(1);
        end
      end
      ST_IDLE: begin
        if (stat_i.in_vld) begin
          s_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.op)
          OP_SEED: begin
            d_d = '0;
            s_d = stat_i.seed_ok ? ST_SEED_RD : ST_IDLE;
          end
          OP_RUN: begin
            e_d = '0;
            c_d = '0;
            d_d = '0;
            s_d = ST_EP_CLR;
          end
          OP_RD_ASG: s_d = ST_RD_OUT;
          OP_RD_CEN: s_d = ST_RD_OUT;
          default:   s_d = ST_IDLE;
        endcase
      end
      ST_SEED_RD: s_d = ST_SEED_WR;
      ST_SEED_WR: begin
        if (d_end) begin
          s_d = ST_IDLE;
        end else begin
          d_d = d_q + DW'(1);
          s_d = ST_SEED_RD;
        end
      end
      ST_RD_OUT: begin
        if (stat_i.out_free) begin
          s_d = ST_IDLE;
        end
      end
      ST_EP_CLR: begin
        if (d_end) begin
          d_d = '0;
          if (c_end) begin
            c_d = '0;
            p_d = '0;
            s_d = ST_DIST;
          end else begin
            c_d = c_q + CLW'(1);
          end
        end else begin
          d_d = d_q + DW'(1);
        end
      end
      ST_DIST: begin
        if (d_end) begin
          d_d = '0;
          if (c_end) begin
            c_d = '0;
            s_d = ST_DIST_WAIT;
          end else begin
            c_d = c_q + CLW'(1);
          end
        end else begin
          d_d = d_q + DW'(1);
        end
      end
      ST_DIST_WAIT: begin
        if (!stat_i.dist_busy) begin
          d_d = '0;
          s_d = ST_ACC_RD;
        end
      end
      ST_ACC_RD: s_d = ST_ACC_WR;
      ST_ACC_WR: begin
        if (d_end) begin
          s_d = ST_ASSIGN;
        end else begin
          d_d = d_q + DW'(1);
          s_d = ST_ACC_RD;
        end
      end
      ST_ASSIGN: begin
        c_d = '0;
        d_d = '0;
        if (p_end) begin
          s_d = (e_q == e_last_i) ? ST_RUN_OUT : ST_UPD_CHK;
        end else begin
          p_d = p_q + PW'(1);
          s_d = ST_DIST;
        end
      end
      ST_UPD_CHK: begin
        d_d = '0;
        if (!stat_i.cnt_zero) begin
          s_d = ST_UPD_RD;
        end else if (c_end) begin
          s_d = ST_EP_NEXT;
        end else begin
          c_d = c_q + CLW'(1);
        end
      end
      ST_UPD_RD:  s_d = ST_UPD_DIV;
      ST_UPD_DIV: s_d = ST_UPD_WAIT;
      ST_UPD_WAIT: begin
        if (stat_i.div_done) begin
          if (!d_end) begin
            d_d = d_q + DW'(1);
            s_d = ST_UPD_RD;
          end else if (c_end) begin
            s_d = ST_EP_NEXT;
          end else begin
            c_d = c_q + CLW'(1);
            s_d = ST_UPD_CHK;
          end
        end
      end
      ST_EP_NEXT: begin
        e_d = e_q + 6'd1;
        c_d = '0;
        d_d = '0;
        s_d = ST_EP_CLR;
      end
      ST_RUN_OUT: begin
        if (stat_i.out_free) begin
          s_d = ST_IDLE;
        end
      end
      default: s_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (s_q)
      ST_CLEAR: cmd_o.asg_we_clr = 1'b1;
      ST_IDLE:  cmd_o.in_rdy = 1'b1;
      ST_DECODE: begin
        cmd_o.pt_we       = (stat_i.op == OP_LOAD) && stat_i.load_ok;
        cmd_o.asg_re      = stat_i.op == OP_RD_ASG;
        cmd_o.cen_re      = stat_i.op == OP_RD_CEN;
        cmd_o.cen_sel_req = 1'b1;
      end
      ST_SEED_RD: begin
        cmd_o.pt_re      = 1'b1;
        cmd_o.pt_sel_req = 1'b1;
      end
      ST_SEED_WR: cmd_o.cen_we_seed = 1'b1;
      ST_RD_OUT: begin
        cmd_o.out_ld_asg = stat_i.out_free && (stat_i.op == OP_RD_ASG);
        cmd_o.out_ld_cen = stat_i.out_free && (stat_i.op == OP_RD_CEN);
      end
      ST_EP_CLR: begin
        cmd_o.sum_we_clr = 1'b1;
        cmd_o.cnt_clr    = 1'b1;
      end
      ST_DIST: begin
        cmd_o.pt_re      = 1'b1;
        cmd_o.cen_re     = 1'b1;
        cmd_o.dist_vld   = 1'b1;
        cmd_o.dist_first = d_q == '0;
        cmd_o.dist_last  = d_end;
      end
      ST_ACC_RD: begin
        cmd_o.pt_re        = 1'b1;
        cmd_o.sum_re       = 1'b1;
        cmd_o.sum_sel_best = 1'b1;
      end
      ST_ACC_WR: begin
        cmd_o.sum_we_acc   = 1'b1;
        cmd_o.sum_sel_best = 1'b1;
      end
      ST_ASSIGN: begin
        cmd_o.asg_we_run = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
      end
      ST_UPD_RD:   cmd_o.sum_re = 1'b1;
      ST_UPD_DIV:  cmd_o.div_start = 1'b1;
      ST_UPD_WAIT: cmd_o.cen_we_upd = stat_i.div_done;
      ST_RUN_OUT:  cmd_o.out_ld_run = stat_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  assign p_o = p_q;
  assign c_o = c_q;
  assign d_o = d_q;
endmodule

// ===== sv/kml_dp.sv =====
// ----------------------------------------------------------------------------
// kml_dp
// Datapath: point, centroid, sum and assignment memories, member counters,
// distance pipeline, mean divider and the result register.
// ----------------------------------------------------------------------------
module kml_dp import kml_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  kml_in_if.sink                                      in_i,
  kml_out_if.source                                   out_o,
  input  kml_cmd_t                                    cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]               p_i,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]             c_i,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] d_i,
  output kml_stat_t                                   stat_o
);
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CLW   = $clog2(MAX_CLUSTERS);
  localparam int PT_N  = MAX_POINTS * MAX_DIMS;
  localparam int CE_N  = MAX_CLUSTERS * MAX_DIMS;
  localparam int PTAW  = (PT_N > 1) ? $clog2(PT_N) : 1;
  localparam int CEAW  = $clog2(CE_N);
  localparam int SW    = COORD_W + $clog2(MAX_POINTS);
  localparam int CNW   = $clog2(MAX_POINTS) + 1;
  localparam int NW    = SW + FRAC_W;
  localparam int PRODW = 2 * CEN_W;
  localparam int ACCW  = PRODW + $clog2(MAX_DIMS + 1);

  // latched operation
  logic [2:0] op_q;
  logic [9:0] pi_q;
  logic [4:0] di_q;
  logic [3:0] ci_q;
  logic [8:0] val_q;
  logic       p_ok, d_ok, c_ok;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && cmd_i.in_rdy) begin
      op_q  <= in_i.operation;
      pi_q  <= in_i.point_index;
      di_q  <= in_i.dim_index;
      ci_q  <= in_i.cluster_index;
      val_q <= in_i.coordinate_value;
    end
  end

  assign in_i.ready = cmd_i.in_rdy;
  assign p_ok = int'(pi_q) < MAX_POINTS;
  assign d_ok = int'(di_q) < MAX_DIMS;
  assign c_ok = int'(ci_q) < MAX_CLUSTERS;

  logic [CLW-1:0] best_c_q;

  // ---- point store
  logic [PTAW-1:0]    pt_waddr, pt_raddr;
  logic [COORD_W-1:0] pt_rdata;

  assign pt_waddr = PTAW'(int'(pi_q) * MAX_DIMS + int'(di_q));
  assign pt_raddr = cmd_i.pt_sel_req ? PTAW'(int'(pi_q) * MAX_DIMS + int'(d_i))
                                     : PTAW'(int'(p_i) * MAX_DIMS + int'(d_i));

  kml_ram #(.W(COORD_W), .DEPTH(PT_N)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (val_q),
    .re_i    (cmd_i.pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // ---- centroid store
  logic [CEAW-1:0]  cen_waddr, cen_raddr;
  logic [CEN_W-1:0] cen_wdata, cen_rdata;
  logic [NW-1:0]    quot;

  assign cen_waddr = cmd_i.cen_we_seed ? CEAW'(int'(ci_q) * MAX_DIMS + int'(d_i))
                                       : CEAW'(int'(c_i) * MAX_DIMS + int'(d_i));
  assign cen_wdata = cmd_i.cen_we_seed ? {pt_rdata, {FRAC_W{1'b0}}} : quot[CEN_W-1:0];
  assign cen_raddr = cmd_i.cen_sel_req ? CEAW'(int'(ci_q) * MAX_DIMS + int'(di_q))
                                       : CEAW'(int'(c_i) * MAX_DIMS + int'(d_i));

  kml_ram #(.W(CEN_W), .DEPTH(CE_N)) u_cen_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cen_we_seed | cmd_i.cen_we_upd),
    .waddr_i (cen_waddr),
    .wdata_i (cen_wdata),
    .re_i    (cmd_i.cen_re),
    .raddr_i (cen_raddr),
    .rdata_o (cen_rdata)
  );

  // ---- per-cluster coordinate sums
  logic [CEAW-1:0] sum_addr;
  logic [SW-1:0]   sum_wdata, sum_rdata;

  assign sum_addr  = cmd_i.sum_sel_best ? CEAW'(int'(best_c_q) * MAX_DIMS + int'(d_i))
                                        : CEAW'(int'(c_i) * MAX_DIMS + int'(d_i));
  assign sum_wdata = cmd_i.sum_we_clr ? '0 : sum_rdata + SW'(pt_rdata);

  kml_ram #(.W(SW), .DEPTH(CE_N)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sum_we_clr | cmd_i.sum_we_acc),
    .waddr_i (sum_addr),
    .wdata_i (sum_wdata),
    .re_i    (cmd_i.sum_re),
    .raddr_i (sum_addr),
    .rdata_o (sum_rdata)
  );

  // ---- assignments
  logic [ASG_W-1:0] asg_wdata, asg_rdata;

  assign asg_wdata = cmd_i.asg_we_clr ? '0 : ASG_W'(best_c_q);

  kml_ram #(.W(ASG_W), .DEPTH(MAX_POINTS)) u_asg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.asg_we_clr | cmd_i.asg_we_run),
    .waddr_i (p_i),
    .wdata_i (asg_wdata),
    .re_i    (cmd_i.asg_re),
    .raddr_i (PW'(pi_q)),
    .rdata_o (asg_rdata)
  );

  // ---- member counters
  logic [CNW-1:0] cnt_q [MAX_CLUSTERS];
  logic [CNW-1:0] cnt_sel;

  assign cnt_sel = cnt_q[c_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.cnt_clr) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.cnt_inc) begin
      cnt_q[best_c_q] <= cnt_q[best_c_q] + CNW'(1);
    end
  end

  // ---- distance pipeline: RAM read, square, accumulate and compare
  logic             v1_q, f1_q, l1_q, v2_q, f2_q, l2_q;
  logic [CLW-1:0]   c1_q, c2_q;
  logic [CEN_W-1:0] pt_fx, diff;
  logic [PRODW-1:0] prod_q;
  logic [ACCW-1:0]  acc_q, best_d_q, acc_nxt;

  assign pt_fx   = {pt_rdata, {FRAC_W{1'b0}}};
  assign diff    = (pt_fx >= cen_rdata) ? pt_fx - cen_rdata : cen_rdata - pt_fx;
  assign acc_nxt = (f2_q ? '0 : acc_q) + ACCW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.dist_vld;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= cmd_i.dist_first;
    l1_q   <= cmd_i.dist_last;
    c1_q   <= c_i;
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    c2_q   <= c1_q;
    prod_q <= diff * diff;
    if (v2_q) begin
      acc_q <= acc_nxt;
      // strict compare keeps the lowest-numbered cluster on a tie
      if (l2_q && ((c2_q == '0) || (acc_nxt < best_d_q))) begin
        best_d_q <= acc_nxt;
        best_c_q <= c2_q;
      end
    end
  end

  // ---- mean
  logic div_done;

  kml_div #(.NW(NW), .DW(CNW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({sum_rdata, {FRAC_W{1'b0}}}),
    .divisor_i  (cnt_sel),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // ---- result register
  logic             out_vld_q, out_run_q;
  logic [ASG_W-1:0] out_asg_q;
  logic [CEN_W-1:0] out_cen_q;
  logic             out_ld;

  assign out_ld = cmd_i.out_ld_asg | cmd_i.out_ld_cen | cmd_i.out_ld_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_asg_q <= (cmd_i.out_ld_asg && p_ok) ? asg_rdata : '0;
      out_cen_q <= (cmd_i.out_ld_cen && c_ok && d_ok) ? cen_rdata : '0;
      out_run_q <= cmd_i.out_ld_run;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.assigned_cluster = out_asg_q;
  assign out_o.centroid_value   = out_cen_q;
  assign out_o.run_done         = out_run_q;

  always_comb begin
    stat_o           = '0;
    stat_o.in_vld    = in_i.valid;
    stat_o.op        = op_q;
    stat_o.load_ok   = p_ok && d_ok;
    stat_o.seed_ok   = p_ok && c_ok;
    stat_o.dist_busy = v1_q | v2_q;
    stat_o.cnt_zero  = cnt_sel == '0;
    stat_o.div_done  = div_done;
    stat_o.out_free  = !out_vld_q || out_o.ready;
  end
endmodule

// ===== sv/kmeans_lloyd_clustering.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering
// Lloyd k-means engine with APB configuration and valid/ready channels.
// ----------------------------------------------------------------------------
// After reset the assignment store is cleared, during which no operation
// beat is taken. A read also waits on the result channel while it is full.
// A run is bounded by the single shared distance path and the bit-serial
// mean divider: each epoch clears the sums, then assigns and accumulates
// every point, and every epoch but the last updates the centroids through
// the divider, whose length is NW = 17 + log2(MAX_POINTS). One operation
// is in flight at a time; results sit in an output register.
module kmeans_lloyd_clustering import kml_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kml_in_if.sink      in_i,
  kml_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int CLW = $clog2(MAX_CLUSTERS);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [4:0]  k_q;
  logic [5:0]  dims_q;
  logic [10:0] n_q;
  logic [5:0]  ep_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= RST_CLUSTERS;
      dims_q <= RST_DIMS;
      n_q    <= RST_POINTS;
      ep_q   <= RST_EPOCHS;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CLUSTERS: k_q    <= pwdata[4:0];
        REG_DIMS:     dims_q <= pwdata[5:0];
        REG_POINTS:   n_q    <= pwdata[10:0];
        REG_EPOCHS:   ep_q   <= pwdata[5:0];
        default:      k_q    <= k_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CLUSTERS: prdata = {27'd0, k_q};
      REG_DIMS:     prdata = {26'd0, dims_q};
      REG_POINTS:   prdata = {21'd0, n_q};
      REG_EPOCHS:   prdata = {26'd0, ep_q};
      default:      prdata = '0;
    endcase
  end

  // last index in use; zero acts as one, too large acts as the maximum
  logic [CLW-1:0] k_last;
  logic [DW-1:0]  d_last;
  logic [PW-1:0]  n_last;
  logic [5:0]     e_last;

  always_comb begin
    if (k_q == '0) begin
      k_last = '0;
    end else if (int'(k_q) > MAX_CLUSTERS) begin
      k_last = CLW'(MAX_CLUSTERS - 1);
    end else begin
      k_last = CLW'(k_q - 5'd1);
    end
    if (dims_q == '0) begin
      d_last = '0;
    end else if (int'(dims_q) > MAX_DIMS) begin
      d_last = DW'(MAX_DIMS - 1);
    end else begin
      d_last = DW'(dims_q - 6'd1);
    end
    if (n_q == '0) begin
      n_last = '0;
    end else if (int'(n_q) > MAX_POINTS) begin
      n_last = PW'(MAX_POINTS - 1);
    end else begin
      n_last = PW'(n_q - 11'd1);
    end
    e_last = (ep_q == '0) ? 6'd0 : ep_q - 6'd1;
  end

  kml_cmd_t       cmd;
  kml_stat_t      stat;
  logic [PW-1:0]  p_idx;
  logic [CLW-1:0] c_idx;
  logic [DW-1:0]  d_idx;

  kml_ctrl #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .k_last_i (k_last),
    .d_last_i (d_last),
    .n_last_i (n_last),
    .e_last_i (e_last),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .p_o      (p_idx),
    .c_o      (c_idx),
    .d_o      (d_idx)
  );

  kml_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .p_i    (p_idx),
    .c_i    (c_idx),
    .d_i    (d_idx),
    .stat_o (stat)
  );

  // a result carries at most one meaningful field
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot0({out_o.run_done, out_o.assigned_cluster != '0,
                              out_o.centroid_value != '0}))
    else $error("result beat carries more than one field");

  // no new operation while the distance pipeline still holds work
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stat.dist_busy)
    else $error("operation taken with distance pipeline busy");

  // a centroid write from the divider only lands in the update phase
  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cen_we_upd |-> $past(cmd.div_start) == 1'b0 && !cmd.in_rdy)
    else $error("centroid update outside update phase");
endmodule
